// File: rtl/core/rclfr_pkg.sv
// Package for the radio-control link frame receiver.
// Holds shared constants, the frame job record and the CRC-8 step function.
// No dependencies.
package rclfr_pkg;

    localparam int FRAME_BYTES_DEF = 14;
    localparam int FRAME_BYTES_MAX = 64;

    // Wide enough for any item count or frame position up to the largest frame.
    localparam int CNT_W = $clog2(FRAME_BYTES_MAX + 1);

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS = 1'b1;

    localparam logic [15:0] TIMEOUT_RST = 16'd500;
    localparam logic [7:0]  ADDRESS_RST = 8'd130;

    // Until the type byte is in, a frame counts as this many bytes.
    localparam logic [8:0] HDR_FULL     = 9'd5;
    // Position from which the length byte sets the frame size.
    localparam logic [8:0] LEN_KNOWN_AT = 9'd3;
    // Position of the type byte, the first byte covered by the CRC.
    localparam int TYPE_POS = 2;

    localparam logic [7:0] CRC_POLY = 8'hD5;

    typedef struct packed {
        logic             err;
        logic             bank;
        logic [CNT_W-1:0] count;
    } t_job;

    localparam int JOB_W = $bits(t_job);

    // One byte of CRC-8, MSB first.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/core/rc_link_frame_receiver.sv
// Top level of the radio-control link frame receiver.
// Depends on rclfr_pkg, rclfr_ram, rclfr_front, rclfr_job_fifo and rclfr_back.
//
// Usage:
// The slave stream carries one received serial byte per word with its
// microsecond arrival time. Bytes are gathered into address, length, type,
// payload and CRC frames. A complete frame with the configured address and a
// good CRC-8 comes out on the master stream as a run of type and payload
// words, tlast on the final one; a bad CRC gives one word with tuser high.
// An input word is taken whenever s_axis_tready is high. With the send side
// idle, the closing byte queues a job, the send side pops it and starts the
// registered frame RAM read, the fetch state captures the byte and the send
// state presents it; each further word is fetched once the last is taken.
// The frame RAM holds two frame banks and a two-entry job queue sits between
// the receive and send sides, so bytes keep flowing while a run drains.
// s_axis_tready drops only while one run is being sent and a second finished
// frame waits behind it.
// A stalled master side holds its word and eventually stalls the input.
// Reset clears the frame position, start time and queue and loads the
// timeout of 500 us and the address 130. Configuration writes take effect at
// once and are meant for an idle block.
module rc_link_frame_receiver #(
    parameter int FRAME_BYTES = rclfr_pkg::FRAME_BYTES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] rx_byte, [39:8] arrival_time_us
    input  logic [39:0]                          s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [7:0] data_byte, [11:8] byte_index, [15:12] zero
    output logic [15:0]                          m_axis_tdata,
    // [0] status
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast,
    input  logic                                 i_cfg_wr_en,
    input  logic [rclfr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rclfr_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int AW = $clog2(FRAME_BYTES) + 1;

    logic [15:0]     r_timeout;
    logic [7:0]      r_own_addr;

    logic            room;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [7:0]      wr_data;
    logic            push;
    rclfr_pkg::t_job push_job;
    rclfr_pkg::t_job head_job;
    logic            fifo_empty;
    logic [1:0]      fifo_count;
    logic            pop;
    logic            busy;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [7:0]      rd_data;
    logic [3:0]      out_index;
    logic [7:0]      out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= rclfr_pkg::TIMEOUT_RST;
            r_own_addr <= rclfr_pkg::ADDRESS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                rclfr_pkg::CFG_TIMEOUT: r_timeout  <= i_cfg_wdata[15:0];
                rclfr_pkg::CFG_ADDRESS: r_own_addr <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Each queued or active job holds one RAM bank; two banks exist.
    assign room = (fifo_count == 2'd0) || ((fifo_count == 2'd1) && !busy);

    rclfr_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_byte     (s_axis_tdata[7:0]),
        .i_time     (s_axis_tdata[39:8]),
        .i_timeout  (r_timeout),
        .i_own_addr (r_own_addr),
        .i_room     (room),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_push     (push),
        .o_job      (push_job)
    );

    rclfr_ram #(
        .WIDTH(8),
        .DEPTH(1 << AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rclfr_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (fifo_empty),
        .o_count (fifo_count)
    );

    rclfr_back #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_job_valid (!fifo_empty),
        .o_pop       (pop),
        .o_busy      (busy),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_status    (m_axis_tuser),
        .o_data      (out_data),
        .o_index     (out_index),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, out_index, out_data};

endmodule

// File: rtl/core/rclfr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module rclfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/rclfr_front.sv
// Receive side: frame timeout, byte placement, running CRC and frame completion.
// Depends on rclfr_pkg; writes frame bytes into one bank of the frame RAM.
module rclfr_front #(
    parameter int FRAME_BYTES = rclfr_pkg::FRAME_BYTES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [7:0]                             i_byte,
    input  logic [31:0]                            i_time,
    input  logic [15:0]                            i_timeout,
    input  logic [7:0]                             i_own_addr,
    input  logic                                   i_room,
    output logic                                   o_wr_en,
    output logic [$clog2(FRAME_BYTES):0]           o_wr_addr,
    output logic [7:0]                             o_wr_data,
    output logic                                   o_push,
    output rclfr_pkg::t_job                        o_job
);

    localparam int IW   = $clog2(FRAME_BYTES);
    localparam int IDXW = $clog2(FRAME_BYTES + 1);

    logic [IDXW-1:0] r_index;
    logic [31:0]     r_start;
    logic [7:0]      r_addr_byte;
    logic [7:0]      r_len;
    logic [7:0]      r_crc;
    logic            r_bank;

    logic [31:0]     elapsed;
    logic            timed_out;
    logic [IDXW-1:0] eff;
    logic [8:0]      eff9;
    logic [8:0]      full;
    logic            take;
    logic            done;
    logic            accept;
    logic [7:0]      crc_seed;

    assign o_ready = i_room;
    assign accept  = i_valid && o_ready;

    // A negative wrap difference is time going backwards and never times out.
    assign elapsed   = i_time - r_start;
    assign timed_out = !elapsed[31] && (elapsed > {16'd0, i_timeout});
    assign eff       = timed_out ? '0 : r_index;
    assign eff9      = 9'(eff);
    assign full      = (eff9 < rclfr_pkg::LEN_KNOWN_AT) ? rclfr_pkg::HDR_FULL
                                                        : ({1'b0, r_len} + 9'd2);
    assign take      = (eff9 < full) && (eff9 < 9'(FRAME_BYTES));
    assign done      = take && ((eff9 + 9'd1) == full);
    assign crc_seed  = (eff9 == 9'(rclfr_pkg::TYPE_POS)) ? 8'd0 : r_crc;

    assign o_wr_en   = accept && take;
    assign o_wr_addr = {r_bank, eff[IW-1:0]};
    assign o_wr_data = i_byte;

    assign o_push      = accept && done && (r_addr_byte == i_own_addr);
    assign o_job.err   = (r_crc != i_byte);
    assign o_job.bank  = r_bank;
    assign o_job.count = rclfr_pkg::CNT_W'(r_len - 8'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_start <= '0;
            r_bank  <= 1'b0;
        end else if (accept) begin
            if (eff == '0) begin
                r_start <= i_time;
            end
            if (done) begin
                r_index <= '0;
            end else if (take) begin
                r_index <= eff + IDXW'(1);
            end else begin
                r_index <= eff;
            end
            if (o_push) begin
                r_bank <= !r_bank;
            end
        end
    end

    // Header bytes and the running CRC over type and payload.
    always_ff @(posedge i_clk) begin
        if (accept && take) begin
            if (eff9 == 9'd0) begin
                r_addr_byte <= i_byte;
            end
            if (eff9 == 9'd1) begin
                r_len <= i_byte;
            end
            if (!done) begin
                r_crc <= rclfr_pkg::crc8_step(crc_seed, i_byte);
            end
        end
    end

endmodule

// File: rtl/core/rclfr_job_fifo.sv
// Two-entry queue of completed frame jobs between the receive and send sides.
// Depends on rclfr_pkg for the job record.
module rclfr_job_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rclfr_pkg::t_job i_job,
    input  logic            i_pop,
    output rclfr_pkg::t_job o_job,
    output logic            o_empty,
    output logic [1:0]      o_count
);

    rclfr_pkg::t_job r_slot [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_count;

    assign o_job   = r_slot[r_rd];
    assign o_empty = (r_count == 2'd0);
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

endmodule

// File: rtl/core/rclfr_back.sv
// Send side: takes a frame job, reads its bytes from the frame RAM and emits words.
// Depends on rclfr_pkg; reads the bank named in the job.
module rclfr_back #(
    parameter int FRAME_BYTES = rclfr_pkg::FRAME_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rclfr_pkg::t_job                i_job,
    input  logic                           i_job_valid,
    output logic                           o_pop,
    output logic                           o_busy,
    output logic                           o_rd_en,
    output logic [$clog2(FRAME_BYTES):0]   o_rd_addr,
    input  logic [7:0]                     i_rd_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_status,
    output logic [7:0]                     o_data,
    output logic [3:0]                     o_index,
    output logic                           o_last
);

    localparam int IW    = $clog2(FRAME_BYTES);
    localparam int CNT_W = rclfr_pkg::CNT_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_SEND  = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic             r_bank;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_pos;
    logic             r_status;
    logic [7:0]       r_data;
    logic             r_last;

    logic             sent;
    logic [CNT_W-1:0] next_pos;
    logic [CNT_W-1:0] rd_pos;

    assign o_valid  = (r_state == S_SEND);
    assign o_busy   = (r_state != S_IDLE);
    assign o_status = r_status;
    assign o_data   = r_data;
    assign o_index  = r_pos[3:0];
    assign o_last   = r_last;

    assign sent     = o_valid && i_ready;
    assign next_pos = r_pos + CNT_W'(1);
    assign o_pop    = (r_state == S_IDLE) && i_job_valid;

    // The type byte sits two places into the frame.
    always_comb begin
        if (r_state == S_IDLE) begin
            rd_pos    = CNT_W'(rclfr_pkg::TYPE_POS);
            o_rd_addr = {i_job.bank, rd_pos[IW-1:0]};
            o_rd_en   = o_pop && !i_job.err;
        end else begin
            rd_pos    = next_pos + CNT_W'(rclfr_pkg::TYPE_POS);
            o_rd_addr = {r_bank, rd_pos[IW-1:0]};
            o_rd_en   = sent && !r_last;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_state = i_job.err ? S_SEND : S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (sent) begin
                    n_state = r_last ? S_IDLE : S_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bank   <= i_job.bank;
            r_count  <= i_job.count;
            r_pos    <= '0;
            r_status <= i_job.err;
            r_data   <= 8'd0;
            r_last   <= 1'b1;
        end else if (r_state == S_FETCH) begin
            r_data <= i_rd_data;
            r_last <= ((r_pos + CNT_W'(1)) == r_count);
        end else if (sent && !r_last) begin
            r_pos <= next_pos;
        end
    end

endmodule
